### rtl/uvf_pkg.sv
// shared constants, status codes and controller/datapath bundles
// for the unique value fifo; no dependencies
`default_nettype none

package uvf_pkg;

   // queue geometry
   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int VAL_W    = 31;
   localparam int IN_W     = 32;
   localparam int STATUS_W = 3;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NEGATIVE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic ready;      // input channel may take a word
      logic accept;     // latch the request word
      logic rem_read;   // read the head slot
      logic scan_init;  // start a duplicate scan at head
      logic scan;       // advance the duplicate scan
      logic commit;     // decide result and update queue state
      logic out_load;   // move result into the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_valid;
      logic op_remove;
      logic neg;
      logic empty;
      logic scan_done;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

### rtl/uvf_if.sv
// valid/ready channel interfaces for requests and results
// depends on uvf_pkg
`default_nettype none

interface uvf_req_if;
   logic                             valid;
   logic                             ready;
   logic                             req_type;
   logic signed [uvf_pkg::IN_W-1:0]  value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface uvf_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [uvf_pkg::STATUS_W-1:0]     status;
   logic [uvf_pkg::VAL_W-1:0]        result_value;

   modport source (output valid, output status, output result_value, input ready);
   modport sink   (input valid, input status, input result_value, output ready);
endinterface

`default_nettype wire

### rtl/uvf_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module uvf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### rtl/uvf_datapath.sv
// queue pointers, request latch, duplicate scan and output register
// depends on uvf_pkg, uvf_if and uvf_ram
`default_nettype none

module uvf_datapath (
   input  wire logic      clock,
   input  wire logic      reset,
   uvf_req_if.sink        req_ch,
   uvf_rsp_if.source      rsp_ch,
   input  uvf_pkg::cmd_type  cmd,
   output uvf_pkg::stat_type stat
);

   localparam int IDX_W    = uvf_pkg::IDX_W;
   localparam int CNT_W    = uvf_pkg::CNT_W;
   localparam int VAL_W    = uvf_pkg::VAL_W;
   localparam int STATUS_W = uvf_pkg::STATUS_W;
   localparam int IN_TOP   = uvf_pkg::IN_W - 1;

   // queue state
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // latched request word
   logic             op_ff, op_in;
   logic             neg_ff, neg_in;
   logic [VAL_W-1:0] val_ff, val_in;

   // duplicate scan
   logic [IDX_W-1:0] scan_addr_ff, scan_addr_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic             pend_ff, pend_in;
   logic             hit_ff, hit_in;

   // pending result and output register
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [VAL_W-1:0]    res_value_ff, res_value_in;
   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [VAL_W-1:0]    out_value_ff, out_value_in;

   // ram ports
   logic             wr_en;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [VAL_W-1:0] rd_data;

   logic queue_full;
   logic queue_empty;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      next_slot = (slot == IDX_W'(uvf_pkg::DEPTH - 1)) ? '0 : slot + 1'b1;
   endfunction

   assign queue_full  = (count_ff == CNT_W'(uvf_pkg::DEPTH));
   assign queue_empty = (count_ff == '0);

   uvf_ram #(
      .WIDTH(VAL_W),
      .DEPTH(uvf_pkg::DEPTH)
   ) u_entries (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(tail_ff),
      .wr_data(val_ff),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // next state
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      neg_in        = neg_ff;
      val_in        = val_ff;
      scan_addr_in  = scan_addr_ff;
      left_in       = left_ff;
      pend_in       = pend_ff;
      hit_in        = hit_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_value_in  = out_value_ff;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = scan_addr_ff;

      // take the request word
      if (cmd.accept) begin
         op_in  = req_ch.req_type;
         neg_in = req_ch.value[IN_TOP];
         val_in = req_ch.value[VAL_W-1:0];
      end

      // remove reads the head slot
      if (cmd.rem_read) begin
         rd_en   = 1'b1;
         rd_addr = head_ff;
      end

      // duplicate scan start
      if (cmd.scan_init) begin
         scan_addr_in = head_ff;
         left_in      = count_ff;
         pend_in      = 1'b0;
         hit_in       = 1'b0;
      end

      // one read issued and one compare per cycle
      if (cmd.scan) begin
         if (left_ff != '0) begin
            rd_en        = 1'b1;
            rd_addr      = scan_addr_ff;
            scan_addr_in = next_slot(scan_addr_ff);
            left_in      = left_ff - 1'b1;
            pend_in      = 1'b1;
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff && (rd_data == val_ff)) begin
            hit_in = 1'b1;
         end
      end

      // decide the result and update the queue
      if (cmd.commit) begin
         res_value_in = '0;
         if (op_ff == uvf_pkg::REQ_REMOVE) begin
            if (queue_empty) begin
               res_status_in = uvf_pkg::ST_EMPTY;
            end else begin
               res_status_in = uvf_pkg::ST_OK;
               res_value_in  = rd_data;
               head_in       = next_slot(head_ff);
               count_in      = count_ff - 1'b1;
            end
         end else if (neg_ff) begin
            res_status_in = uvf_pkg::ST_NEGATIVE;
         end else if (hit_ff) begin
            res_status_in = uvf_pkg::ST_DUPLICATE;
         end else if (queue_full) begin
            res_status_in = uvf_pkg::ST_FULL;
         end else begin
            res_status_in = uvf_pkg::ST_OK;
            res_value_in  = val_ff;
            wr_en         = 1'b1;
            tail_in       = next_slot(tail_ff);
            count_in      = count_ff + 1'b1;
         end
      end

      // output register
      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_value_in  = res_value_ff;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      neg_ff        <= neg_in;
      val_ff        <= val_in;
      scan_addr_ff  <= scan_addr_in;
      hit_ff        <= hit_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      out_status_ff <= out_status_in;
      out_value_ff  <= out_value_in;
   end

   // channel outputs and status
   assign req_ch.ready        = cmd.ready;
   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.status       = out_status_ff;
   assign rsp_ch.result_value = out_value_ff;

   assign stat.req_valid = req_ch.valid;
   assign stat.op_remove = (op_ff == uvf_pkg::REQ_REMOVE);
   assign stat.neg       = neg_ff;
   assign stat.empty     = queue_empty;
   assign stat.scan_done = (left_ff == '0) && !pend_ff;
   assign stat.out_free  = !out_valid_ff || rsp_ch.ready;

endmodule

`default_nettype wire

### rtl/uvf_ctrl.sv
// request sequencer for the unique value fifo
// depends on uvf_pkg
`default_nettype none

module uvf_ctrl (
   input  wire logic         clock,
   input  wire logic         reset,
   input  uvf_pkg::stat_type stat,
   output uvf_pkg::cmd_type  cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_SCAN  = 5'b00100,
      S_RWAIT = 5'b01000,
      S_DONE  = 5'b10000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.op_remove) begin
               if (stat.empty) begin
                  cmd.commit = 1'b1;
                  state_in   = S_DONE;
               end else begin
                  cmd.rem_read = 1'b1;
                  state_in     = S_RWAIT;
               end
            end else if (stat.neg) begin
               cmd.commit = 1'b1;
               state_in   = S_DONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_done) begin
               cmd.commit = 1'b1;
               state_in   = S_DONE;
            end
         end
         S_RWAIT: begin
            cmd.commit = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/unique_value_fifo_unit.sv
// unique value fifo: an insert scans every word held in the queue for a duplicate, one read
// per cycle over the entry ram; a remove reads the head slot, while a negative insert or a
// remove from an empty queue is decided without a ram read.
// One word at a time; a finished result waits in the output register while the next word
// is taken. Synchronous active-high reset empties the queue (head, tail and count to zero).
// depends on uvf_pkg, uvf_if, uvf_ctrl and uvf_datapath
`default_nettype none

module unique_value_fifo_unit (
   input  wire logic clock,
   input  wire logic reset,
   uvf_req_if.sink   req_ch,
   uvf_rsp_if.source rsp_ch
);

   uvf_pkg::cmd_type  cmd;
   uvf_pkg::stat_type stat;

   // sequencer
   uvf_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .stat (stat),
      .cmd  (cmd)
   );

   // queue storage and scan
   uvf_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule

`default_nettype wire

### dv/uvf_result_check.sv
// result checker for the unique value fifo: watches both channels, keeps its own
// copy of the queue and compares every result word; depends on uvf_pkg and uvf_if
`default_nettype none

module uvf_result_check (
   input  wire logic clock,
   input  wire logic reset,
   uvf_req_if        req_mon,
   uvf_rsp_if        rsp_mon,
   output int        fail_count,
   output int        outstanding
);

   localparam int DEPTH    = uvf_pkg::DEPTH;
   localparam int IDX_W    = uvf_pkg::IDX_W;
   localparam int CNT_W    = uvf_pkg::CNT_W;
   localparam int VAL_W    = uvf_pkg::VAL_W;
   localparam int IN_W     = uvf_pkg::IN_W;
   localparam int STATUS_W = uvf_pkg::STATUS_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [VAL_W-1:0]    value;
   } rsp_word_type;

   // shadow copy of the queue
   logic [VAL_W-1:0] held [DEPTH];
   logic [IDX_W-1:0] head_slot;
   logic [IDX_W-1:0] tail_slot;
   logic [CNT_W-1:0] held_count;

   // expected result words, oldest first
   rsp_word_type expected_rsp_q [$];

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      return (slot == IDX_W'(DEPTH - 1)) ? '0 : slot + 1'b1;
   endfunction

   // apply one request to the shadow queue and return its result word
   task automatic predict_request(input logic kind, input logic [IN_W-1:0] word,
                                  output rsp_word_type res);
      logic [IDX_W-1:0] slot;
      logic             seen;
      res.status = uvf_pkg::ST_OK;
      res.value  = '0;
      seen       = 1'b0;
      slot       = head_slot;
      if (kind == uvf_pkg::REQ_INSERT) begin
         // duplicate scan, oldest entry first
         for (int n = 0; n < held_count; n++) begin
            if (held[slot] == word[VAL_W-1:0])
               seen = 1'b1;
            slot = next_slot(slot);
         end
         // negative wins over duplicate, duplicate over full
         if (word[IN_W-1])
            res.status = uvf_pkg::ST_NEGATIVE;
         else if (seen)
            res.status = uvf_pkg::ST_DUPLICATE;
         else if (held_count == CNT_W'(DEPTH))
            res.status = uvf_pkg::ST_FULL;
         else begin
            held[tail_slot] = word[VAL_W-1:0];
            tail_slot       = next_slot(tail_slot);
            held_count      = held_count + 1'b1;
            res.value       = word[VAL_W-1:0];
         end
      end else begin
         if (held_count == '0)
            res.status = uvf_pkg::ST_EMPTY;
         else begin
            res.value  = held[head_slot];
            head_slot  = next_slot(head_slot);
            held_count = held_count - 1'b1;
         end
      end
   endtask

   // compare result words first, then queue up the prediction for a new request
   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         head_slot  = '0;
         tail_slot  = '0;
         held_count = '0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.status = rsp_mon.status;
            got.value  = rsp_mon.result_value;
            if (expected_rsp_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result word, expected none, got status %0d value %0h",
                        $time, got.status, got.value);
            end else begin
               want = expected_rsp_q.pop_front();
               if (got.status !== want.status) begin
                  fail_count++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want.status, got.status);
               end
               if (got.value !== want.value) begin
                  fail_count++;
                  $display("%0t: result_value mismatch, expected %0h, got %0h",
                           $time, want.value, got.value);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.req_type, req_mon.value, want);
            expected_rsp_q.push_back(want);
         end
      end
      outstanding <= expected_rsp_q.size();
   end

endmodule

`default_nettype wire

### dv/unique_value_fifo_unit_tb.sv
// testbench top for the unique value fifo: drives request words, idles both
// channels at random and gives the verdict; depends on uvf_pkg, uvf_if,
// unique_value_fifo_unit and uvf_result_check
`default_nettype none

module unique_value_fifo_unit_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RESET_CYCLES = 12;
   localparam int LONG_HOLD = 400;
   localparam int SEGMENTS = 25;
   localparam int SEGMENT_WORDS = 61;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   outstanding;
   int   idle_mode;     // 0: no idling on either side
   logic rsp_hold_now;  // asks the receiver for one long hold-off

   uvf_req_if req_ch ();
   uvf_rsp_if rsp_ch ();

   unique_value_fifo_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   uvf_result_check u_result_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // insert values: small pool for duplicates, negatives, extremes, wide values
   function automatic logic [uvf_pkg::IN_W-1:0] pick_value();
      int unsigned              r;
      logic [uvf_pkg::IN_W-1:0] w;
      r = $urandom_range(0, 99);
      w = $urandom();
      if (r < 45)
         w = $urandom_range(0, 23);
      else if (r < 55)
         w[uvf_pkg::IN_W-1] = 1'b1;
      else if (r < 60) begin
         case ($urandom_range(0, 3))
            0:       w = 32'h0000_0000;
            1:       w = 32'h7FFF_FFFF;
            2:       w = 32'hFFFF_FFFF;
            default: w = 32'h8000_0000;
         endcase
      end else
         w[uvf_pkg::IN_W-1] = 1'b0;
      return w;
   endfunction

   // offer one request word, hold it until taken, then maybe idle
   task automatic offer(input logic kind, input logic [uvf_pkg::IN_W-1:0] word);
      int gap;
      req_ch.valid    <= 1'b1;
      req_ch.req_type <= kind;
      req_ch.value    <= word;
      do @(posedge clock); while (!req_ch.ready);
      gap = (idle_mode != 0) ? idle_length() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop sending until every expected result word has come back
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // receiver side: random stalls, a long hold-off on request
   initial begin : rsp_side
      int stall;
      rsp_ch.ready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_now) begin
            rsp_hold_now = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (idle_mode == 0) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat (1 + $urandom_range(0, 6)) @(posedge clock);
            stall = idle_length();
            if (stall > 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // run limit
   initial begin : watchdog
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin : stimulus
      int insert_pct;
      req_ch.valid    = 1'b0;
      req_ch.req_type = uvf_pkg::REQ_INSERT;
      req_ch.value    = '0;
      idle_mode       = 1;
      rsp_hold_now    = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // remove from an empty queue
      offer(uvf_pkg::REQ_REMOVE, 32'hFFFF_FFFF);
      // smallest and largest values, then the two negative extremes
      offer(uvf_pkg::REQ_INSERT, 32'h0000_0000);
      offer(uvf_pkg::REQ_INSERT, 32'h7FFF_FFFF);
      offer(uvf_pkg::REQ_INSERT, 32'h8000_0000);
      offer(uvf_pkg::REQ_INSERT, 32'hFFFF_FFFF);
      // duplicates of both extremes
      offer(uvf_pkg::REQ_INSERT, 32'h0000_0000);
      offer(uvf_pkg::REQ_INSERT, 32'h7FFF_FFFF);
      // fill the queue
      for (int i = 0; i < uvf_pkg::DEPTH - 2; i++)
         offer(uvf_pkg::REQ_INSERT, 32'd1 << i);
      // full queue: new value, duplicate, negative
      offer(uvf_pkg::REQ_INSERT, 32'h5555_5555);
      offer(uvf_pkg::REQ_INSERT, 32'd1);
      offer(uvf_pkg::REQ_INSERT, 32'hAAAA_AAAA);
      offer(uvf_pkg::REQ_REMOVE, 32'h0000_0000);
      wait_drained();

      // random segments, each with its own insert/remove balance
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         case ($urandom_range(0, 2))
            0:       insert_pct = 30;
            1:       insert_pct = 55;
            default: insert_pct = 80;
         endcase
         idle_mode = (seg % 4 == 1) ? 0 : 1;
         // receiver holds off while requests keep coming
         if (seg == 2) begin
            idle_mode    = 0;
            insert_pct   = 80;
            rsp_hold_now = 1'b1;
         end
         for (int k = 0; k < SEGMENT_WORDS; k++) begin
            if ($urandom_range(0, 99) < insert_pct)
               offer(uvf_pkg::REQ_INSERT, pick_value());
            else
               offer(uvf_pkg::REQ_REMOVE, $urandom());
         end
         if (seg == 0 || $urandom_range(0, 3) == 0)
            wait_drained();
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
rtl/uvf_pkg.sv
rtl/uvf_if.sv
rtl/uvf_ram.sv
rtl/uvf_datapath.sv
rtl/uvf_ctrl.sv
rtl/unique_value_fifo_unit.sv
dv/uvf_result_check.sv
dv/unique_value_fifo_unit_tb.sv
